/* hdl/etip_pkg.sv */
// ----------------------------------------------------------------------------
// etip_pkg: shared types and constants of the eased tween interpolator
// fixed point format, easing mode codes, register indexes, quarter sine table
// ----------------------------------------------------------------------------
package etip_pkg;

    localparam int FRAC_BITS  = 15;
    localparam int SINE_DEPTH = 256;
    localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
    localparam logic [16:0] ONE = 17'd1 << FRAC_BITS;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // register indexes
    localparam logic [1:0] REG_START    = 2'd0;
    localparam logic [1:0] REG_END      = 2'd1;
    localparam logic [1:0] REG_DURATION = 2'd2;
    localparam logic [1:0] REG_MODE     = 2'd3;

    // easing modes
    localparam logic [3:0] MODE_LINEAR       = 4'd0;
    localparam logic [3:0] MODE_QUAD_IN      = 4'd1;
    localparam logic [3:0] MODE_QUAD_OUT     = 4'd2;
    localparam logic [3:0] MODE_QUAD_INOUT   = 4'd3;
    localparam logic [3:0] MODE_SINE_IN      = 4'd4;
    localparam logic [3:0] MODE_SINE_OUT     = 4'd5;
    localparam logic [3:0] MODE_SINE_INOUT   = 4'd6;
    localparam logic [3:0] MODE_BOUNCE_IN    = 4'd7;
    localparam logic [3:0] MODE_BOUNCE_OUT   = 4'd8;
    localparam logic [3:0] MODE_BOUNCE_INOUT = 4'd9;

    typedef logic [15:0] t_sine_tab [SINE_DEPTH+1];

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic div_init;
        logic div_step;
        logic arg;
        logic ops;
        logic mul;
        logic ease;
        logic scale;
        logic rnd;
        logic load_out;
    } t_cmd;

    // shift and subtract quotient, only used while building the table
    function automatic longint unsigned div_u64(longint unsigned a, longint unsigned b);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], a[i]};
            if (rem >= b) begin
                rem    = rem - b;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // quarter wave sin(k/DEPTH * pi/2) in q15, taylor series in q30
    function automatic t_sine_tab build_sine();
        t_sine_tab tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned den;
        longint sum;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            x    = (HALF_PI_Q30 * 64'(k)) >> SINE_IDX_W;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 12; n++) begin
                den  = 64'((2 * n) * (2 * n + 1));
                term = div_u64((term * x2) >> 30, den);
                if ((n & 1) == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
            tab[k] = 16'((64'(sum) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
        end
        tab[0]          = 16'd0;
        tab[SINE_DEPTH] = ONE[15:0];
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();

endpackage

/* hdl/eased_tween_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// eased_tween_interpolator_unit: eased tween value generator
// animates one value from start to end along a selectable easing curve
// ----------------------------------------------------------------------------
// usage
//   request channel: i_valid / o_ready with i_req_type (0 advance, 1 restart)
//   and i_delta_ticks; a request is taken when both are high
//   result channel: o_valid / i_ready with o_value, o_eased_progress (q1.15)
//   and o_done_res; one result per request
//   config: write i_cfg_data to register i_cfg_idx when i_cfg_we is high,
//   0 start, 1 end, 2 duration, 3 ease mode; write only while idle
// timing
//   one request at a time; each request passes the restoring divider for
//   elapsed / duration, then the argument, operand, multiply, ease, scale
//   and round steps, and waits in its last step to load the output register
//   a new request is taken while the last result still waits in the output
//   register; a stalled receiver only holds the next result in its last step
// reset
//   synchronous active low; elapsed and done cleared, start/end 0,
//   duration 1, linear mode, no result pending
// ----------------------------------------------------------------------------
module eased_tween_interpolator_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_req_type,
    input  logic [15:0]        i_delta_ticks,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_value,
    output logic [15:0]        o_eased_progress,
    output logic               o_done_res,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);

    // command bundle from sequencer to datapath
    etip_pkg::t_cmd cmd;

    // sequencer: walks a request through divide, ease, scale, output
    etip_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    // datapath: registers, elapsed count, arithmetic, output register
    etip_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_req_type       (i_req_type),
        .i_delta_ticks    (i_delta_ticks),
        .o_value          (o_value),
        .o_eased_progress (o_eased_progress),
        .o_done_res       (o_done_res)
    );

endmodule

/* hdl/etip_ctrl.sv */
// ----------------------------------------------------------------------------
// etip_ctrl: sequencing controller
// steps one request through division, easing and scaling, owns output valid
// ----------------------------------------------------------------------------
module etip_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output etip_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DINIT, S_DIV, S_ARG, S_OPS, S_MUL, S_EASE, S_SCALE, S_RND, S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic       r_ovalid, n_ovalid;
    logic       load;

    assign load = (r_state == S_OUT) && (!r_ovalid || i_ready);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid;
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_DINIT;
            S_DINIT: begin
                n_cnt   = 4'd0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd14) n_state = S_ARG;
            end
            S_ARG:   n_state = S_OPS;
            S_OPS:   n_state = S_MUL;
            S_MUL:   n_state = S_EASE;
            S_EASE:  n_state = S_SCALE;
            S_SCALE: n_state = S_RND;
            S_RND:   n_state = S_OUT;
            S_OUT: begin
                if (load) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= 4'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = (r_state == S_IDLE) && i_valid;
        o_cmd.div_init = (r_state == S_DINIT);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.arg      = (r_state == S_ARG);
        o_cmd.ops      = (r_state == S_OPS);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.ease     = (r_state == S_EASE);
        o_cmd.scale    = (r_state == S_SCALE);
        o_cmd.rnd      = (r_state == S_RND);
        o_cmd.load_out = load;
    end

endmodule

/* hdl/etip_dpath.sv */
// ----------------------------------------------------------------------------
// etip_dpath: tween datapath
// config registers, elapsed state, serial divider, easing and scaling stages
// ----------------------------------------------------------------------------
module etip_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  etip_pkg::t_cmd     i_cmd,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_req_type,
    input  logic [15:0]        i_delta_ticks,
    output logic signed [15:0] o_value,
    output logic [15:0]        o_eased_progress,
    output logic               o_done_res
);

    logic signed [15:0] r_start, r_end;
    logic [15:0] r_dur;
    logic [3:0]  r_mode;
    logic [15:0] r_elapsed, n_elapsed;
    logic        r_fin, n_fin;
    logic [15:0] r_rem;
    logic [14:0] r_quo;
    logic [15:0] r_x;
    logic        r_half;
    logic [16:0] r_ma, r_mb;
    logic [15:0] r_lo;
    logic [1:0]  r_seg;
    logic [33:0] r_prod;
    logic [15:0] r_e;
    logic signed [34:0] r_sprod;
    logic [15:0] r_val;
    logic signed [15:0] r_o_value;
    logic [15:0] r_o_eq;
    logic        r_o_done;

    logic [15:0] dur_eff;
    assign dur_eff = (r_dur == 16'd0) ? 16'd1 : r_dur;

    // config and elapsed state
    logic [16:0] t_sum;
    always_comb begin
        n_elapsed = r_elapsed;
        n_fin     = r_fin;
        t_sum     = {1'b0, r_elapsed} + {1'b0, i_delta_ticks};
        if (i_req_type) begin
            n_elapsed = 16'd0;
            n_fin     = 1'b0;
        end else if (!r_fin) begin
            n_elapsed = (t_sum > {1'b0, dur_eff}) ? dur_eff : t_sum[15:0];
            if (n_elapsed >= dur_eff) n_fin = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= '0;
            r_end     <= '0;
            r_dur     <= 16'd1;
            r_mode    <= etip_pkg::MODE_LINEAR;
            r_elapsed <= '0;
            r_fin     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    etip_pkg::REG_START:    r_start <= i_cfg_data;
                    etip_pkg::REG_END:      r_end   <= i_cfg_data;
                    etip_pkg::REG_DURATION: r_dur   <= i_cfg_data;
                    etip_pkg::REG_MODE:     r_mode  <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_elapsed <= n_elapsed;
                r_fin     <= n_fin;
            end
        end
    end

    // restoring divider, one quotient bit a cycle
    logic [16:0] div_sh;
    assign div_sh = {r_rem, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= r_elapsed;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            if (div_sh >= {1'b0, dur_eff}) begin
                r_rem <= 16'(div_sh - {1'b0, dur_eff});
                r_quo <= {r_quo[13:0], 1'b1};
            end else begin
                r_rem <= div_sh[15:0];
                r_quo <= {r_quo[13:0], 1'b0};
            end
        end
    end

    // argument of the inner curve and half select for in-out modes
    logic [16:0] p17, two_p, x_n;
    logic        half_n;
    always_comb begin
        p17    = {2'b0, r_quo};
        two_p  = {1'b0, r_quo, 1'b0};
        x_n    = p17;
        half_n = 1'b0;
        case (r_mode)
            etip_pkg::MODE_SINE_IN, etip_pkg::MODE_BOUNCE_IN: x_n = etip_pkg::ONE - p17;
            etip_pkg::MODE_QUAD_INOUT: begin
                half_n = (two_p >= etip_pkg::ONE);
                x_n    = half_n ? two_p - etip_pkg::ONE : p17;
            end
            etip_pkg::MODE_SINE_INOUT: begin
                half_n = (two_p > etip_pkg::ONE);
                x_n    = half_n ? two_p - etip_pkg::ONE : etip_pkg::ONE - two_p;
            end
            etip_pkg::MODE_BOUNCE_INOUT: begin
                half_n = (two_p >= etip_pkg::ONE);
                x_n    = half_n ? two_p - etip_pkg::ONE : etip_pkg::ONE - two_p;
            end
            default: x_n = p17;
        endcase
    end

    // multiplier operands per curve
    logic [8:0]  s_idx, s_idx1;
    logic [15:0] s_lo, s_hi, s_diff;
    logic [19:0] p11, p22;
    logic [16:0] ma_n, mb_n, bd;
    logic [1:0]  seg_n;
    always_comb begin
        s_idx  = r_x[15:7];
        s_idx1 = s_idx + 9'd1;
        s_lo   = etip_pkg::SINE_TAB[s_idx];
        s_hi   = (s_idx == 9'(etip_pkg::SINE_DEPTH)) ? s_lo : etip_pkg::SINE_TAB[s_idx1];
        s_diff = (s_hi > s_lo) ? s_hi - s_lo : 16'd0;
        p11    = ({4'b0, r_x} << 3) + ({4'b0, r_x} << 1) + {4'b0, r_x};
        p22    = p11 << 1;
        if (p11 < 20'd131072) begin
            seg_n = 2'd0;
            bd    = p11[16:0];
        end else if (p11 < 20'd262144) begin
            seg_n = 2'd1;
            bd    = 17'((p11 > 20'd196608) ? p11 - 20'd196608 : 20'd196608 - p11);
        end else if (p11 < 20'd327680) begin
            seg_n = 2'd2;
            bd    = 17'((p11 > 20'd294912) ? p11 - 20'd294912 : 20'd294912 - p11);
        end else begin
            seg_n = 2'd3;
            bd    = 17'((p22 > 20'd688128) ? p22 - 20'd688128 : 20'd688128 - p22);
        end
        ma_n = '0;
        mb_n = '0;
        case (r_mode)
            etip_pkg::MODE_QUAD_IN: begin
                ma_n = {1'b0, r_x};
                mb_n = {1'b0, r_x};
            end
            etip_pkg::MODE_QUAD_OUT: begin
                ma_n = {1'b0, r_x};
                mb_n = 17'(18'h10000 - {2'b0, r_x});
            end
            etip_pkg::MODE_QUAD_INOUT: begin
                ma_n = {1'b0, r_x};
                mb_n = r_half ? 17'(18'h10000 - {2'b0, r_x}) : {1'b0, r_x};
            end
            etip_pkg::MODE_SINE_IN, etip_pkg::MODE_SINE_OUT, etip_pkg::MODE_SINE_INOUT: begin
                ma_n = {1'b0, s_diff};
                mb_n = {10'b0, r_x[6:0]};
            end
            etip_pkg::MODE_BOUNCE_IN, etip_pkg::MODE_BOUNCE_OUT,
            etip_pkg::MODE_BOUNCE_INOUT: begin
                ma_n = bd;
                mb_n = bd;
            end
            default: ;
        endcase
    end

    // finish the curve from the product
    logic [34:0] pr;
    logic [17:0] q_rnd, q_lo, q_hi, s_val, bo, r_n;
    always_comb begin
        pr    = {1'b0, r_prod};
        q_rnd = 18'((pr + 35'd16384) >> 15);
        q_lo  = 18'(((pr << 1) + 35'd16384) >> 15);
        q_hi  = 18'((pr + 35'h40000000 + 35'd32768) >> 16);
        s_val = {2'b0, r_lo} + 18'((pr + 35'd64) >> 7);
        case (r_seg)
            2'd0:    bo = 18'((pr + 35'h40000) >> 19);
            2'd1:    bo = 18'((pr + 35'h40000) >> 19) + 18'd24576;
            2'd2:    bo = 18'((pr + 35'h40000) >> 19) + 18'd30720;
            default: bo = 18'((pr + 35'h100000) >> 21) + 18'd32256;
        endcase
        if (bo > {1'b0, etip_pkg::ONE}) bo = {1'b0, etip_pkg::ONE};
        case (r_mode)
            etip_pkg::MODE_QUAD_IN, etip_pkg::MODE_QUAD_OUT: r_n = q_rnd;
            etip_pkg::MODE_QUAD_INOUT: r_n = r_half ? q_hi : q_lo;
            etip_pkg::MODE_SINE_IN:    r_n = {1'b0, etip_pkg::ONE} - s_val;
            etip_pkg::MODE_SINE_OUT:   r_n = s_val;
            etip_pkg::MODE_SINE_INOUT:
                r_n = r_half ? ({1'b0, etip_pkg::ONE} + s_val + 18'd1) >> 1
                             : ({1'b0, etip_pkg::ONE} - s_val + 18'd1) >> 1;
            etip_pkg::MODE_BOUNCE_IN:  r_n = {1'b0, etip_pkg::ONE} - bo;
            etip_pkg::MODE_BOUNCE_OUT: r_n = bo;
            etip_pkg::MODE_BOUNCE_INOUT:
                r_n = r_half ? ({1'b0, etip_pkg::ONE} + bo + 18'd1) >> 1
                             : ({1'b0, etip_pkg::ONE} - bo + 18'd1) >> 1;
            default: r_n = {3'b0, r_quo};
        endcase
        if (r_n > {1'b0, etip_pkg::ONE} || r_fin) r_n = {1'b0, etip_pkg::ONE};
    end

    // scale and round, halves away from zero
    logic signed [16:0] span;
    logic [34:0] mag;
    logic [19:0] qm;
    logic signed [20:0] qs, vsum;
    always_comb begin
        span = $signed({r_end[15], r_end}) - $signed({r_start[15], r_start});
        mag  = r_sprod[34] ? 35'(-r_sprod) : 35'(r_sprod);
        qm   = 20'((mag + 35'd16384) >> 15);
        qs   = r_sprod[34] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
        vsum = qs + 21'(r_start);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.arg) begin
            r_x    <= x_n[15:0];
            r_half <= half_n;
        end
        if (i_cmd.ops) begin
            r_ma  <= ma_n;
            r_mb  <= mb_n;
            r_lo  <= s_lo;
            r_seg <= seg_n;
        end
        if (i_cmd.mul) r_prod <= r_ma * r_mb;
        if (i_cmd.ease) r_e <= r_n[15:0];
        if (i_cmd.scale) r_sprod <= 35'(span) * 35'($signed({2'b0, r_e}));
        if (i_cmd.rnd) r_val <= vsum[15:0];
        if (i_cmd.load_out) begin
            r_o_value <= r_val;
            r_o_eq    <= r_e;
            r_o_done  <= r_fin;
        end
    end

    assign o_value          = r_o_value;
    assign o_eased_progress = r_o_eq;
    assign o_done_res       = r_o_done;

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench of the eased tween interpolator
// drives advance and restart requests under random idling and long result
// stalls, predicts every easing curve in fixed point and checks each result
// ----------------------------------------------------------------------------
module tb_top;

    localparam bit REQ_ADVANCE = 1'b0;
    localparam bit REQ_RESTART = 1'b1;
    localparam int IDLE_GAP    = 40;

    typedef struct {
        logic signed [15:0] value;
        logic [15:0]        progress;
        logic               done;
    } t_tween_res;

    // ------------------------------------------------------------------------
    // tween predictor: own copy of registers and state, fills expected queue
    // ------------------------------------------------------------------------
    class tween_scoreboard;
        logic [15:0] start_r, end_r, dur_r;
        logic [3:0]  mode_r;
        logic [15:0] elapsed_q;
        bit          finished_q;
        longint unsigned qtr_sine [etip_pkg::SINE_DEPTH+1];
        t_tween_res  pending [$];
        int          errors;

        function new();
            longint unsigned x, x2, term;
            longint sum;
            start_r = 0; end_r = 0; dur_r = 1; mode_r = etip_pkg::MODE_LINEAR;
            elapsed_q = 0; finished_q = 0; errors = 0;
            for (int k = 0; k <= etip_pkg::SINE_DEPTH; k++) begin
                x = (64'd1686629713 * 64'(k)) / etip_pkg::SINE_DEPTH;
                x2 = (x * x) >> 30;
                term = x;
                sum = longint'(x);
                for (int n = 1; n <= 12; n++) begin
                    term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) sum -= longint'(term);
                    else sum += longint'(term);
                end
                if (sum < 0) sum = 0;
                if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
                qtr_sine[k] = (64'(sum) + (64'd1 << 14)) >> 15;
            end
            qtr_sine[0] = 0;
            qtr_sine[etip_pkg::SINE_DEPTH] = 32768;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                etip_pkg::REG_START:    start_r = data;
                etip_pkg::REG_END:      end_r   = data;
                etip_pkg::REG_DURATION: dur_r   = data;
                etip_pkg::REG_MODE:     mode_r  = data[3:0];
                default: ;
            endcase
        endfunction

        function longint unsigned sine_at(longint unsigned x);
            longint unsigned pos, idx, frac, lo, hi;
            if (x > 32768) x = 32768;
            pos = x * etip_pkg::SINE_DEPTH;
            idx = pos >> 15;
            frac = pos & 32767;
            if (idx >= etip_pkg::SINE_DEPTH) return qtr_sine[etip_pkg::SINE_DEPTH];
            lo = qtr_sine[idx];
            hi = qtr_sine[idx + 1];
            if (hi < lo) hi = lo;
            return lo + (((hi - lo) * frac + 16384) >> 15);
        endfunction

        function longint unsigned bounce_at(longint unsigned p);
            longint unsigned p11, d, r, one;
            one = 32768;
            p11 = 11 * p;
            if (p11 < 4 * one) return (p11 * p11 + (one << 3)) >> 19;
            else if (p11 < 8 * one) begin
                d = (p11 > 6 * one) ? p11 - 6 * one : 6 * one - p11;
                r = ((d * d + (one << 3)) >> 19) + ((3 * one) >> 2);
            end else if (p11 < 10 * one) begin
                d = (p11 > 9 * one) ? p11 - 9 * one : 9 * one - p11;
                r = ((d * d + (one << 3)) >> 19) + ((15 * one) >> 4);
            end else begin
                d = (2 * p11 > 21 * one) ? 2 * p11 - 21 * one : 21 * one - 2 * p11;
                r = ((d * d + (one << 5)) >> 21) + ((63 * one) >> 6);
            end
            return r > one ? one : r;
        endfunction

        function longint unsigned eased(longint unsigned p);
            longint unsigned r, u, one;
            one = 32768;
            case (mode_r)
                etip_pkg::MODE_QUAD_IN:  r = (p * p + 16384) >> 15;
                etip_pkg::MODE_QUAD_OUT: r = (p * (2 * one - p) + 16384) >> 15;
                etip_pkg::MODE_QUAD_INOUT:
                    if (2 * p < one) r = (2 * p * p + 16384) >> 15;
                    else begin
                        u = 2 * p - one;
                        r = (u * (2 * one - u) + one * one + one) >> 16;
                    end
                etip_pkg::MODE_SINE_IN:  r = one - sine_at(one - p);
                etip_pkg::MODE_SINE_OUT: r = sine_at(p);
                etip_pkg::MODE_SINE_INOUT:
                    if (2 * p <= one) r = (one - sine_at(one - 2 * p) + 1) >> 1;
                    else r = (one + sine_at(2 * p - one) + 1) >> 1;
                etip_pkg::MODE_BOUNCE_IN:  r = one - bounce_at(one - p);
                etip_pkg::MODE_BOUNCE_OUT: r = bounce_at(p);
                etip_pkg::MODE_BOUNCE_INOUT:
                    if (2 * p < one) r = (one - bounce_at(one - 2 * p) + 1) >> 1;
                    else r = (bounce_at(2 * p - one) + one + 1) >> 1;
                default: r = p;
            endcase
            return r > one ? one : r;
        endfunction

        // accepted request: step the state and queue the expected result
        function void note_request(bit restart, logic [15:0] delta);
            longint unsigned dur, t, e;
            longint span, prod, q;
            t_tween_res res;
            dur = (dur_r == 0) ? 1 : dur_r;
            if (restart) begin
                elapsed_q = 0;
                finished_q = 0;
            end else if (!finished_q) begin
                t = elapsed_q + delta;
                elapsed_q = 16'((t > dur) ? dur : t);
            end
            if (!finished_q && elapsed_q >= dur) finished_q = 1;
            if (finished_q) e = 32768;
            else e = eased((longint'(elapsed_q) << 15) / dur);
            span = longint'($signed(end_r)) - longint'($signed(start_r));
            prod = span * longint'(e);
            if (prod >= 0) q = (prod + 16384) >>> 15;
            else q = -((-prod + 16384) >>> 15);
            res.value = 16'(longint'($signed(start_r)) + q);
            res.progress = 16'(e);
            res.done = finished_q;
            pending = {pending, res};
        endfunction

        function void check_result(logic signed [15:0] value, logic [15:0] prog, logic done);
            t_tween_res exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result value %0d", $time, value);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (value !== exp_r.value) begin
                $display("%0t: value exp %0d got %0d", $time, exp_r.value, value);
                errors++;
            end
            if (prog !== exp_r.progress) begin
                $display("%0t: progress exp %0d got %0d", $time, exp_r.progress, prog);
                errors++;
            end
            if (done !== exp_r.done) begin
                $display("%0t: done exp %0b got %0b", $time, exp_r.done, done);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_ready;
    logic               i_req_type = 0;
    logic [15:0]        i_delta_ticks = 0;
    logic               o_valid;
    logic               i_ready = 0;
    logic signed [15:0] o_value;
    logic [15:0]        o_eased_progress;
    logic               o_done_res;
    logic               i_cfg_we = 0;
    logic [1:0]         i_cfg_idx = 0;
    logic [15:0]        i_cfg_data = 0;

    tween_scoreboard tracker = new();
    int  send_idle_pct = 12;
    int  recv_idle_pct = 65;
    bit  recv_hold = 0;

    eased_tween_interpolator_unit dut (.*);

    always #2 i_clk = ~i_clk;

    // watchdog: far above the slowest correct run
    initial begin
        #4000000;
        $display("tb_top: FAIL");
        $finish;
    end

    // result side: random ready, long holds on request, check on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            tracker.check_result(o_value, o_eased_progress, o_done_res);
        i_ready <= i_rst_n && !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // one register write, then the write enable is low again before returning
    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 0;
        tracker.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    // wait for all results, then past the block latency before touching regs
    task automatic drain();
        i_valid <= 0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (IDLE_GAP) @(posedge i_clk);
    endtask

    task automatic configure(logic [15:0] s, logic [15:0] e, logic [15:0] d, logic [3:0] m);
        drain();
        write_reg(etip_pkg::REG_START, s);
        write_reg(etip_pkg::REG_END, e);
        write_reg(etip_pkg::REG_DURATION, d);
        write_reg(etip_pkg::REG_MODE, m);
    endtask

    // one request; idle gaps are drawn before valid rises, never mid-request
    task automatic send_req(bit restart, logic [15:0] delta);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_req_type <= restart;
        i_delta_ticks <= delta;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_request(restart, delta);
    endtask

    task automatic random_tween(output int count);
        logic [15:0] dur, d;
        int steps;
        dur = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40));
        if ($urandom_range(19) == 0) dur = 0;
        configure(16'($urandom), 16'($urandom), dur, 4'($urandom_range(15)));
        send_req(REQ_RESTART, 16'($urandom));
        steps = $urandom_range(12, 3);
        for (int k = 0; k < steps; k++) begin
            // mostly small steps so the curve is walked, now and then a jump
            case ($urandom_range(9))
                0: d = 16'($urandom);
                1: d = 0;
                default: d = 16'($urandom_range((dur / 4) + 1));
            endcase
            send_req(($urandom_range(15) == 0) ? REQ_RESTART : REQ_ADVANCE, d);
        end
        count = steps + 1;
    endtask

    initial begin
        int sent;
        int n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset settings: duration one, finishes on the first nonzero advance
        send_req(REQ_ADVANCE, 0);
        send_req(REQ_ADVANCE, 16'hffff);
        // every mode over a short tween, extreme start and end
        for (int m = 0; m < 16; m += (m < 10 ? 1 : 5)) begin
            configure(16'h8000, 16'h7fff, 16'd8, 4'(m));
            send_req(REQ_RESTART, 16'hffff);
            send_req(REQ_ADVANCE, 16'd3);
            send_req(REQ_ADVANCE, 16'd4);
            send_req(REQ_ADVANCE, 16'd100);
            // after done, a register change keeps progress at full and done set
            if (m == 0) begin
                configure(16'h7fff, 16'h8000, 16'hffff, etip_pkg::MODE_SINE_INOUT);
                send_req(REQ_ADVANCE, 16'd1);
            end
        end
        // zero duration and shortened duration
        configure(16'd100, 16'hff9c, 16'd0, etip_pkg::MODE_QUAD_OUT);
        send_req(REQ_RESTART, 0);
        send_req(REQ_ADVANCE, 0);
        configure(16'h7fff, 16'h8000, 16'hffff, etip_pkg::MODE_BOUNCE_INOUT);
        send_req(REQ_RESTART, 0);
        send_req(REQ_ADVANCE, 16'h8000);
        drain();
        write_reg(etip_pkg::REG_DURATION, 16'd10);
        send_req(REQ_ADVANCE, 16'd1);

        // receiver holds off while the sender keeps offering
        fork
            begin
                recv_hold = 1;
                repeat (300) @(posedge i_clk);
                recv_hold = 0;
            end
            for (int k = 0; k < 6; k++) send_req(REQ_ADVANCE, 16'($urandom));
        join

        sent = 0;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 65 : 0;
            recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 12 : 0;
            while (sent < 300 * (phase + 1)) begin
                random_tween(n);
                sent += n;
            end
        end

        drain();
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hdl/etip_pkg.sv
hdl/etip_ctrl.sv
hdl/etip_dpath.sv
hdl/eased_tween_interpolator_unit.sv
sim/tb_top.sv
